// ----- design/s5uot_pkg.sv -----
// shared types and constants for the socks5 udp-over-tcp receive deframer
// no dependencies

package s5uot_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_CONNECT = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FAILED  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_DATA   = 2'd0,
        EV_AUTH   = 2'd1,
        EV_STREAM = 2'd2,
        EV_FAIL   = 2'd3
    } event_t;

    localparam logic [7:0]  SOCKS_VER      = 8'h05;
    localparam logic [7:0]  ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0]  ATYP_IPV6      = 8'h04;
    localparam logic [8:0]  REPLY_LEN_IPV4 = 9'd10;
    localparam logic [8:0]  REPLY_LEN_IPV6 = 9'd22;
    localparam logic [8:0]  REPLY_LEN_NAME = 9'd7;
    localparam logic [8:0]  FRAME_HDR_LAST = 9'd8;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd2048;

    localparam int OUT_DATA_W = 72;

endpackage

// ----- design/socks5_uot_stream_deframer_top.sv -----
// socks5 udp-over-tcp receive deframer: reply checks, frame header parse, payload out
// depends on s5uot_pkg
//
// Usage:
//   s_axis carries the tunnel receive stream, one byte per transaction in tdata.
//   m_axis carries results: tuser is the event (payload byte, auth accepted,
//   tunnel streaming, tunnel failure), tdata packs data byte, frame address,
//   port and payload length, tlast marks the final payload byte of a frame.
//   cfg_we/cfg_wdata write the frame length limit (reset 2048), sampled on the
//   last header byte of each frame; write it only while the block is idle.
//   Latency: a result appears on m_axis the cycle after its byte is accepted.
//   Throughput: one byte per cycle while the result register is free or being taken;
//   all parsing for a byte is combinational, in the cycle of its input handshake.
//   Bytes that give no result (reply bytes, header bytes) are simply consumed.
//   If the receiver stalls, the result register holds and s_axis_tready drops
//   until the pending result is taken, so no result is lost.
//   Reset returns to waiting for the method reply; after a failure event every
//   byte is accepted and dropped until the next reset.

module socks5_uot_stream_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [s5uot_pkg::OUT_DATA_W-1:0] m_axis_tdata,
        // [7:0] data_byte, [39:8] dest_ip, [55:40] frame port, [71:56] frame length
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res
    output logic        m_axis_tlast    // last
);
    import s5uot_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [8:0]  byte_index_reg, byte_index_next;
    logic [8:0]  reply_length_reg, reply_length_next;
    logic        status_ok_reg, status_ok_next;
    logic [31:0] frame_addr_reg, frame_addr_next;
    logic [15:0] frame_port_reg, frame_port_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] max_len_reg;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [1:0]            m_user_reg;
    logic                  m_last_reg;

    logic        in_fire;
    logic [7:0]  b;
    logic        res_valid;
    event_t      res_event;
    logic [OUT_DATA_W-1:0] res_data;
    logic        res_last;

    // shared decode
    logic        method_ok;
    logic        conn_ok_new;
    logic [8:0]  conn_len_new;
    logic        conn_done;
    logic [15:0] hdr_len_new;
    logic        hdr_done;
    logic        hdr_fail;
    logic        pay_last;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign method_ok = status_ok_reg && (b == 8'h00);

    always_comb
    begin
        conn_ok_new = status_ok_reg;
        if ((byte_index_reg == 9'd0) && (b != SOCKS_VER))
        begin
            conn_ok_new = 1'b0;
        end
        if ((byte_index_reg == 9'd1) && (b != 8'h00))
        begin
            conn_ok_new = 1'b0;
        end
        conn_len_new = reply_length_reg;
        if (byte_index_reg == 9'd3)
        begin
            if (b == ATYP_IPV6)
                conn_len_new = REPLY_LEN_IPV6;
            else if (b == ATYP_DOMAIN)
                conn_len_new = REPLY_LEN_NAME;
            else
                conn_len_new = REPLY_LEN_IPV4;
        end
        // domain reply: length byte follows the address type
        if ((byte_index_reg == 9'd4) && (reply_length_reg == REPLY_LEN_NAME))
        begin
            conn_len_new = REPLY_LEN_NAME + {1'b0, b};
        end
    end

    assign conn_done = (({1'b0, byte_index_reg} + 10'd1) >= {1'b0, conn_len_new})
                       && (byte_index_reg >= 9'd4);

    assign hdr_len_new = {frame_len_reg[7:0], b};
    assign hdr_done    = (byte_index_reg == FRAME_HDR_LAST);
    assign hdr_fail    = !status_ok_reg || (hdr_len_new > max_len_reg);
    assign pay_last    = (remaining_reg <= 16'd1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_METHOD:
            begin
                if (byte_index_reg != 9'd0)
                    phase_next = method_ok ? PH_CONNECT : PH_FAILED;
            end
            PH_CONNECT:
            begin
                if (conn_done)
                    phase_next = conn_ok_new ? PH_HEADER : PH_FAILED;
            end
            PH_HEADER:
            begin
                if (hdr_done)
                begin
                    if (hdr_fail)
                        phase_next = PH_FAILED;
                    else if (hdr_len_new != 16'd0)
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (pay_last)
                    phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_FAILED;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        byte_index_next   = byte_index_reg;
        reply_length_next = reply_length_reg;
        status_ok_next    = status_ok_reg;
        frame_addr_next   = frame_addr_reg;
        frame_port_next   = frame_port_reg;
        frame_len_next    = frame_len_reg;
        remaining_next    = remaining_reg;
        res_valid         = 1'b0;
        res_event         = EV_DATA;
        res_data          = '0;
        res_last          = 1'b0;
        case (phase_reg)
            PH_METHOD:
            begin
                if (byte_index_reg == 9'd0)
                begin
                    status_ok_next  = (b == SOCKS_VER);
                    byte_index_next = 9'd1;
                end
                else
                begin
                    res_valid = 1'b1;
                    if (method_ok)
                    begin
                        res_event         = EV_AUTH;
                        byte_index_next   = 9'd0;
                        reply_length_next = REPLY_LEN_IPV4;
                        status_ok_next    = 1'b1;
                    end
                    else
                    begin
                        res_event = EV_FAIL;
                    end
                end
            end
            PH_CONNECT:
            begin
                status_ok_next    = conn_ok_new;
                reply_length_next = conn_len_new;
                if (conn_done)
                begin
                    res_valid = 1'b1;
                    if (conn_ok_new)
                    begin
                        res_event       = EV_STREAM;
                        byte_index_next = 9'd0;
                        status_ok_next  = 1'b1;
                    end
                    else
                    begin
                        res_event = EV_FAIL;
                    end
                end
                else
                begin
                    byte_index_next = byte_index_reg + 9'd1;
                end
            end
            PH_HEADER:
            begin
                if (byte_index_reg == 9'd0)
                begin
                    status_ok_next  = (b == 8'h00);
                    frame_addr_next = '0;
                    frame_port_next = '0;
                    frame_len_next  = '0;
                end
                else if (byte_index_reg <= 9'd4)
                begin
                    frame_addr_next = {frame_addr_reg[23:0], b};
                end
                else if (byte_index_reg <= 9'd6)
                begin
                    frame_port_next = {frame_port_reg[7:0], b};
                end
                else
                begin
                    frame_len_next = hdr_len_new;
                end
                if (hdr_done)
                begin
                    byte_index_next = 9'd0;
                    if (hdr_fail)
                    begin
                        res_valid = 1'b1;
                        res_event = EV_FAIL;
                    end
                    else if (hdr_len_new != 16'd0)
                    begin
                        remaining_next = hdr_len_new;
                    end
                end
                else
                begin
                    byte_index_next = byte_index_reg + 9'd1;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid = 1'b1;
                res_event = EV_DATA;
                res_data  = {frame_len_reg, frame_port_reg, frame_addr_reg, b};
                res_last  = pay_last;
                if (pay_last)
                begin
                    remaining_next  = '0;
                    byte_index_next = 9'd0;
                end
                else
                begin
                    remaining_next = remaining_reg - 16'd1;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_METHOD;
            byte_index_reg   <= '0;
            reply_length_reg <= REPLY_LEN_IPV4;
            status_ok_reg    <= 1'b1;
            frame_addr_reg   <= '0;
            frame_port_reg   <= '0;
            frame_len_reg    <= '0;
            remaining_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            reply_length_reg <= reply_length_next;
            status_ok_reg    <= status_ok_next;
            frame_addr_reg   <= frame_addr_next;
            frame_port_reg   <= frame_port_next;
            frame_len_reg    <= frame_len_next;
            remaining_reg    <= remaining_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (in_fire && res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            m_data_reg <= res_data;
            m_user_reg <= res_event;
            m_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // failure is sticky until reset
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED |=> phase_reg == PH_FAILED)
        else $error("left failed phase");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_last_reg |-> m_user_reg == EV_DATA)
        else $error("tlast on a non-payload event");

    a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> byte_index_reg <= FRAME_HDR_LAST)
        else $error("header byte index out of range");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != 16'd0)
        else $error("payload phase with nothing remaining");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

// ----- tb/sv/tb_socks5_uot_stream_deframer_top.sv -----
// testbench for socks5_uot_stream_deframer_top: byte stream in, checked results out
// depends on s5uot_pkg and the deframer top level, nothing else

module tb_socks5_uot_stream_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import s5uot_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        event_t      ev;
        logic [7:0]  data;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] len;
        logic        last;
    } deframe_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [15:0]           cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    logic [7:0]   tunnel_bytes[$];
    deframe_res_t expected_out[$];
    int           src_idle = 38;
    int           snk_idle = 76;
    int           n_err = 0;
    int           cycles = 0;

    // predictor state
    phase_t      ph = PH_METHOD;
    logic [8:0]  idx = '0;
    logic [8:0]  rlen = REPLY_LEN_IPV4;
    logic        ok = 1'b1;
    logic [31:0] f_addr = '0;
    logic [15:0] f_port = '0;
    logic [15:0] f_len = '0;
    logic [15:0] remaining = '0;
    logic [15:0] max_len = MAX_LEN_RESET;

    socks5_uot_stream_deframer_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void push_result(event_t ev, logic [7:0] d, logic l);
        deframe_res_t r;
        r.ev   = ev;
        r.data = (ev == EV_DATA) ? d : 8'h00;
        r.ip   = (ev == EV_DATA) ? f_addr : 32'h0;
        r.port = (ev == EV_DATA) ? f_port : 16'h0;
        r.len  = (ev == EV_DATA) ? f_len : 16'h0;
        r.last = (ev == EV_DATA) ? l : 1'b0;
        expected_out.push_back(r);
    endfunction

    function automatic void tunnel_fail();
        ph = PH_FAILED;
        push_result(EV_FAIL, 8'h00, 1'b0);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic fin;
        case (ph)
            PH_METHOD:
            begin
                if (idx == 0)
                begin
                    ok  = (b == SOCKS_VER);
                    idx = 9'd1;
                end
                else if (!(ok && b == 8'h00))
                    tunnel_fail();
                else
                begin
                    ph   = PH_CONNECT;
                    idx  = '0;
                    rlen = REPLY_LEN_IPV4;
                    ok   = 1'b1;
                    push_result(EV_AUTH, 8'h00, 1'b0);
                end
            end
            PH_CONNECT:
            begin
                if (idx == 0 && b != SOCKS_VER)
                    ok = 1'b0;
                if (idx == 1 && b != 8'h00)
                    ok = 1'b0;
                if (idx == 3)
                    rlen = (b == ATYP_IPV6) ? REPLY_LEN_IPV6 :
                           (b == ATYP_DOMAIN) ? REPLY_LEN_NAME : REPLY_LEN_IPV4;
                // domain name replies grow by the name length byte
                if (idx == 4 && rlen == REPLY_LEN_NAME)
                    rlen = REPLY_LEN_NAME + {1'b0, b};
                if (int'(idx) + 1 >= int'(rlen) && idx >= 4)
                begin
                    if (!ok)
                        tunnel_fail();
                    else
                    begin
                        ph  = PH_HEADER;
                        idx = '0;
                        ok  = 1'b1;
                        push_result(EV_STREAM, 8'h00, 1'b0);
                    end
                end
                else
                    idx = idx + 9'd1;
            end
            PH_HEADER:
            begin
                if (idx == 0)
                begin
                    ok     = (b == 8'h00);
                    f_addr = '0;
                    f_port = '0;
                    f_len  = '0;
                end
                else if (idx <= 4)
                    f_addr = {f_addr[23:0], b};
                else if (idx <= 6)
                    f_port = {f_port[7:0], b};
                else
                    f_len = {f_len[7:0], b};
                if (idx != FRAME_HDR_LAST)
                    idx = idx + 9'd1;
                else
                begin
                    idx = '0;
                    if (!ok || f_len > max_len)
                        tunnel_fail();
                    else if (f_len != 0)
                    begin
                        remaining = f_len;
                        ph        = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                fin       = (remaining <= 16'd1);
                remaining = remaining - 16'd1;
                if (fin)
                begin
                    remaining = '0;
                    ph        = PH_HEADER;
                    idx       = '0;
                end
                push_result(EV_DATA, b, fin);
            end
            default:
            begin
            end
        endcase
    endfunction

    // byte driver: holds tvalid until the transaction completes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tunnel_bytes.size() != 0 && $urandom_range(99) >= src_idle)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tunnel_bytes.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : mon
        deframe_res_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: ev %0d tdata %h last %b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (m_axis_tuser !== want.ev || m_axis_tdata[7:0] !== want.data ||
                        m_axis_tdata[39:8] !== want.ip || m_axis_tdata[55:40] !== want.port ||
                        m_axis_tdata[71:56] !== want.len || m_axis_tlast !== want.last)
                    begin
                        n_err++;
                        if (n_err <= 10)
                        begin
                            $display("mismatch: exp ev %0d data %h ip %h port %h len %h last %b",
                                     want.ev, want.data, want.ip, want.port, want.len,
                                     want.last);
                            $display("          got ev %0d data %h ip %h port %h len %h last %b",
                                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                                     m_axis_tdata[55:40], m_axis_tdata[71:56], m_axis_tlast);
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (tunnel_bytes.size() != 0 || s_axis_tvalid || expected_out.size() != 0)
            @(posedge clk);
    endtask

    // register written only with the pipe empty; the extra wait covers header-only bytes
    task automatic write_max_len(input logic [15:0] v);
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        max_len = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_header(input logic [7:0] kind, input logic [31:0] addr,
                               input logic [15:0] port, input logic [15:0] len);
        tunnel_bytes.push_back(kind);
        for (int i = 3; i >= 0; i--)
            tunnel_bytes.push_back(addr[8*i +: 8]);
        tunnel_bytes.push_back(port[15:8]);
        tunnel_bytes.push_back(port[7:0]);
        tunnel_bytes.push_back(len[15:8]);
        tunnel_bytes.push_back(len[7:0]);
    endtask

    task automatic send_frame(input logic [31:0] addr, input logic [15:0] port,
                              input logic [15:0] len);
        send_header(8'h00, addr, port, len);
        for (int i = 0; i < len; i++)
            tunnel_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_connect_reply();
        logic [7:0] atyp;
        logic [7:0] nlen;
        int         rest;
        case ($urandom_range(3))
            0: atyp = ATYP_IPV6;
            1: atyp = ATYP_DOMAIN;
            2: atyp = 8'h01;
            default:
                do
                    atyp = 8'($urandom_range(255));
                while (atyp == ATYP_DOMAIN || atyp == ATYP_IPV6);
        endcase
        tunnel_bytes.push_back(SOCKS_VER);
        tunnel_bytes.push_back(8'h00);
        tunnel_bytes.push_back(8'($urandom_range(255)));
        tunnel_bytes.push_back(atyp);
        if (atyp == ATYP_DOMAIN)
        begin
            case ($urandom_range(3))
                0: nlen = 8'h00;
                1: nlen = 8'hFF;
                default: nlen = 8'($urandom_range(1, 40));
            endcase
            tunnel_bytes.push_back(nlen);
            rest = int'(REPLY_LEN_NAME) + nlen - 5;
        end
        else
            rest = ((atyp == ATYP_IPV6) ? int'(REPLY_LEN_IPV6) : int'(REPLY_LEN_IPV4)) - 4;
        for (int i = 0; i < rest; i++)
            tunnel_bytes.push_back(8'($urandom_range(255)));
    endtask

    // any protocol fault is terminal, so random frames are always well formed
    task automatic random_frames(input int n_bytes);
        int          sent;
        int          hi;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] len;
        sent = 0;
        while (sent < n_bytes)
        begin
            hi = ($urandom_range(19) == 0) ? 300 : 16;
            if (hi > max_len)
                hi = max_len;
            len  = 16'($urandom_range(0, hi));
            addr = $urandom();
            port = 16'($urandom_range(65535));
            case ($urandom_range(7))
                0: begin addr = '0; port = '0; end
                1: begin addr = '1; port = '1; end
                default: ;
            endcase
            send_frame(addr, port, len);
            sent += 9 + len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // method reply, connect reply, then corner frames at the reset limit
        tunnel_bytes.push_back(SOCKS_VER);
        tunnel_bytes.push_back(8'h00);
        send_connect_reply();
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd1);
        send_frame(32'h0000_0000, 16'h0000, 16'd2);

        write_max_len(16'hFFFF);
        random_frames(500);

        src_idle = 76;
        snk_idle = 38;
        // zero limit: only empty frames pass, and they give no result
        write_max_len(16'h0000);
        for (int i = 0; i < 3; i++)
            send_frame($urandom(), 16'($urandom_range(65535)), 16'd0);
        write_max_len(16'd7);
        send_frame($urandom(), 16'($urandom_range(65535)), 16'd7);
        send_frame($urandom(), 16'($urandom_range(65535)), 16'd6);
        random_frames(150);
        write_max_len(16'($urandom_range(65535)));
        random_frames(450);

        src_idle = 0;
        snk_idle = 0;
        write_max_len(MAX_LEN_RESET);
        random_frames(550);

        // terminal fault: bad frame type or oversized length, then ignored noise
        if ($urandom_range(1) == 1)
            send_header(8'($urandom_range(1, 255)), $urandom(), 16'($urandom_range(65535)),
                        16'($urandom_range(0, max_len)));
        else
            send_header(8'h00, $urandom(), 16'($urandom_range(65535)),
                        16'($urandom_range(int'(max_len) + 1, 65535)));
        for (int i = 0; i < 16; i++)
            tunnel_bytes.push_back(8'($urandom_range(255)));

        wait_drained();
        repeat (10) @(posedge clk);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/s5uot_pkg.sv
design/socks5_uot_stream_deframer_top.sv
tb/sv/tb_socks5_uot_stream_deframer_top.sv
